>>> hw/rtl/frfcfs_pkg.sv
// Package for the FR-FCFS request selector: payload structs, codes and tables.
// No dependencies.
package frfcfs_pkg;

   localparam logic [2:0] MODE_SET_ROW   = 3'd0;
   localparam logic [2:0] MODE_MISS_SET  = 3'd1;
   localparam logic [2:0] MODE_MISS_CLR  = 3'd2;
   localparam logic [2:0] MODE_BANK_IDLE = 3'd3;
   localparam logic [2:0] MODE_BANK_BUSY = 3'd4;
   localparam logic [2:0] MODE_REQUEST   = 3'd5;

   localparam logic [3:0] RULE_FCFS = 4'd0;
   localparam logic [3:0] RULE_PRE  = 4'd1;
   localparam logic [3:0] RULE_TBL0 = 4'd2;
   localparam logic [3:0] RULE_TBL1 = 4'd3;
   localparam logic [3:0] RULE_TBL2 = 4'd4;
   localparam logic [3:0] RULE_TBL3 = 4'd5;
   localparam logic [3:0] RULE_TBL4 = 4'd6;
   localparam logic [3:0] RULE_TBL5 = 4'd7;
   localparam logic [3:0] RULE_TBL6 = 4'd8;

   localparam logic [3:0] CMD_OTHER        = 4'd0;
   localparam logic [3:0] CMD_ACT          = 4'd1;
   localparam logic [3:0] CMD_RD           = 4'd2;
   localparam logic [3:0] CMD_RDA          = 4'd3;
   localparam logic [3:0] CMD_WR           = 4'd4;
   localparam logic [3:0] CMD_WRA          = 4'd5;
   localparam logic [3:0] CMD_NDP_DB_RD    = 4'd6;
   localparam logic [3:0] CMD_NDP_DB_WR    = 4'd7;
   localparam logic [3:0] CMD_NDP_DRAM_RD  = 4'd8;
   localparam logic [3:0] CMD_NDP_DRAM_RDA = 4'd9;
   localparam logic [3:0] CMD_NDP_DRAM_WR  = 4'd10;
   localparam logic [3:0] CMD_NDP_DRAM_WRA = 4'd11;

   localparam logic [7:0] FETCH_THRESHOLD_RESET = 8'd8;

   // Number of bank slots the 6-bit bank index can address.
   localparam int BANK_SLOTS = 64;

   typedef struct packed {
      logic [2:0]  mode;
      logic [3:0]  select_rule;
      logic [5:0]  bank_index;
      logic [15:0] row;
      logic [3:0]  command;
      logic [3:0]  end_command;
      logic        is_read;
      logic        timing_ready;
      logic [7:0]  fetch_count;
      logic [31:0] arrival;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [5:0] chosen_position;
      logic       found;
   } rsp_type;

   // Classified request handed from front to back.
   typedef struct packed {
      logic        ready;
      logic        table_rule;
      logic        pre_rule;
      logic [1:0]  prio;
      logic        elig;
      logic [31:0] arrival;
      logic        last;
   } cls_type;

   function automatic logic [1:0] table_prio(input logic [3:0] rule, input logic [3:0] cmd);
      logic [1:0] p;
      p = 2'd0;
      case (rule)
         RULE_TBL0: if (cmd == CMD_RD) p = 2'd1;
         RULE_TBL1: if (cmd == CMD_NDP_DB_RD) p = 2'd1;
         RULE_TBL2: if (cmd == CMD_NDP_DB_WR) p = 2'd1;
         RULE_TBL3: if (cmd == CMD_NDP_DRAM_RD) p = 2'd2;
                    else if (cmd == CMD_NDP_DRAM_RDA) p = 2'd1;
         RULE_TBL4: if (cmd == CMD_NDP_DRAM_WR) p = 2'd2;
                    else if (cmd == CMD_NDP_DRAM_WRA) p = 2'd1;
         RULE_TBL5: if (cmd == CMD_NDP_DB_RD) p = 2'd3;
                    else if (cmd == CMD_NDP_DRAM_RD) p = 2'd2;
                    else if (cmd == CMD_NDP_DRAM_RDA) p = 2'd1;
         RULE_TBL6: if (cmd == CMD_WR) p = 2'd1;
         default: p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

>>> hw/rtl/frfcfs_front.sv
// Front part: per-bank status tables, request classification.
// Depends on frfcfs_pkg.
module frfcfs_front #(
   parameter int NUM_BANKS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  frfcfs_pkg::req_type   in_req,
   input  logic [7:0]            fetch_threshold,
   output logic                  cls_valid,
   output frfcfs_pkg::cls_type   cls
);
   localparam int SLOTS = frfcfs_pkg::BANK_SLOTS;
   // Previous open row per bank; prev_v_ff marks the rows that were ever set.
   logic [15:0] prev_row_ff [SLOTS];
   logic [SLOTS-1:0] prev_v_ff, prev_v_in, miss_ff, miss_in, idle_ff, idle_in;
   logic in_range, low, ready, elig, tbl, pre, match;
   logic [1:0] prio;
   logic [5:0] b;
   // Stage register: the accepted request with its bank status read at acceptance.
   logic s1_v_ff;
   frfcfs_pkg::req_type s1_req_ff;
   logic [15:0] s1_row_ff;
   logic s1_rowv_ff, s1_miss_ff, s1_idle_ff;

   assign b = in_req.bank_index;
   assign in_range = {26'd0, b} < NUM_BANKS;

   always_comb begin
      prev_v_in = prev_v_ff;
      miss_in = miss_ff;
      idle_in = idle_ff;
      if (in_valid && in_range) begin
         case (in_req.mode)
            frfcfs_pkg::MODE_SET_ROW:   prev_v_in[b] = 1'b1;
            frfcfs_pkg::MODE_MISS_SET:  miss_in[b] = 1'b1;
            frfcfs_pkg::MODE_MISS_CLR:  miss_in[b] = 1'b0;
            frfcfs_pkg::MODE_BANK_IDLE: idle_in[b] = 1'b1;
            frfcfs_pkg::MODE_BANK_BUSY: idle_in[b] = 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_range && in_req.mode == frfcfs_pkg::MODE_SET_ROW)
         prev_row_ff[b] <= in_req.row;
      // Out-of-range banks read as idle, no miss, no previous row.
      s1_req_ff <= in_req;
      s1_row_ff <= prev_row_ff[b];
      s1_rowv_ff <= in_range && prev_v_ff[b];
      s1_miss_ff <= in_range && miss_ff[b];
      s1_idle_ff <= !in_range || idle_ff[b];
      if (reset) begin
         prev_v_ff <= '0;
         miss_ff <= '0;
         idle_ff <= '1;
         s1_v_ff <= 1'b0;
      end else begin
         prev_v_ff <= prev_v_in;
         miss_ff <= miss_in;
         idle_ff <= idle_in;
         s1_v_ff <= in_valid && in_req.mode == frfcfs_pkg::MODE_REQUEST;
      end
   end

   always_comb begin
      match = s1_rowv_ff && s1_row_ff == s1_req_ff.row;
      low = s1_req_ff.command == frfcfs_pkg::CMD_ACT && s1_idle_ff && s1_miss_ff && match;
      tbl = s1_req_ff.select_rule >= frfcfs_pkg::RULE_TBL0
            && s1_req_ff.select_rule <= frfcfs_pkg::RULE_TBL6;
      pre = s1_req_ff.select_rule == frfcfs_pkg::RULE_PRE;
      prio = frfcfs_pkg::table_prio(s1_req_ff.select_rule, s1_req_ff.command);
      elig = (s1_req_ff.is_read ? (s1_req_ff.end_command == frfcfs_pkg::CMD_RD
                                   || s1_req_ff.end_command == frfcfs_pkg::CMD_RDA)
                                : (s1_req_ff.end_command == frfcfs_pkg::CMD_WR
                                   || s1_req_ff.end_command == frfcfs_pkg::CMD_WRA))
             && s1_req_ff.fetch_count < fetch_threshold;
      ready = !low && s1_req_ff.timing_ready && (!pre || elig) && (!tbl || prio != 2'd0);
   end

   assign cls_valid = s1_v_ff;
   assign cls = '{ready: ready, table_rule: tbl, pre_rule: pre, prio: prio, elig: elig,
                  arrival: s1_req_ff.arrival, last: s1_req_ff.last};
endmodule

>>> hw/rtl/frfcfs_fifo.sv
// Small queue of classified requests between front and back.
// Depends on frfcfs_pkg.
module frfcfs_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  frfcfs_pkg::cls_type wr_data,
   output logic                full,
   output logic                almost_full,
   input  logic                rd_en,
   output frfcfs_pkg::cls_type rd_data,
   output logic                empty
);
   localparam int AW = $clog2(DEPTH);
   frfcfs_pkg::cls_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;

   assign full  = cnt_ff == (AW+1)'(DEPTH);
   assign almost_full = cnt_ff >= (AW+1)'(DEPTH-1);
   assign empty = cnt_ff == '0;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (rd_en) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(wr_en) - (AW+1)'(rd_en);
      end
   end
endmodule

>>> hw/rtl/frfcfs_back.sv
// Back part: folds classified requests against the running best, emits winner.
// Depends on frfcfs_pkg.
module frfcfs_back #(
   parameter int MAX_SCAN = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cls_empty,
   input  frfcfs_pkg::cls_type cls,
   output logic                cls_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output frfcfs_pkg::rsp_type rsp_data
);
   localparam int PW = $clog2(MAX_SCAN);
   logic [PW-1:0] pos_ff, pos_in, bpos_ff, bpos_in;
   logic [31:0] barr_ff, barr_in;
   logic bready_ff, bready_in, belig_ff, belig_in, take, done;
   logic [1:0] bprio_ff, bprio_in;
   logic out_v_ff, out_v_in;
   frfcfs_pkg::rsp_type out_ff, out_in;

   // Fold freely; hold a scan-ending request only while the result slot is taken.
   assign cls_pop = !cls_empty && (!done || !out_v_ff || rsp_pop);
   assign rsp_empty = !out_v_ff;
   assign rsp_data = out_ff;

   always_comb begin
      if (pos_ff == '0) take = 1'b1;
      else if (cls.ready != bready_ff) take = cls.ready;
      else if (cls.table_rule && cls.ready && cls.prio != bprio_ff) take = cls.prio > bprio_ff;
      else take = cls.arrival < barr_ff;
      done = cls.last || pos_ff == PW'(MAX_SCAN-1);
      bpos_in = bpos_ff; barr_in = barr_ff; bready_in = bready_ff;
      bprio_in = bprio_ff; belig_in = belig_ff; pos_in = pos_ff;
      out_v_in = out_v_ff && !rsp_pop;
      out_in = out_ff;
      if (cls_pop) begin
         if (take) begin
            bpos_in = pos_ff; barr_in = cls.arrival; bready_in = cls.ready;
            bprio_in = cls.prio; belig_in = cls.elig;
         end
         if (done) begin
            pos_in = '0;
            out_v_in = 1'b1;
            out_in.chosen_position = 6'(bpos_in);
            out_in.found = cls.pre_rule ? belig_in : 1'b1;
         end else pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      barr_ff <= barr_in; bprio_ff <= bprio_in; belig_ff <= belig_in;
      bpos_ff <= bpos_in; out_ff <= out_in;
      if (reset) begin
         pos_ff <= '0; bready_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in; bready_ff <= bready_in; out_v_ff <= out_v_in;
      end
   end
endmodule

>>> hw/rtl/frfcfs_request_selector.sv
// Top level of the FR-FCFS request selector.
// Depends on frfcfs_pkg, frfcfs_front, frfcfs_fifo, frfcfs_back.
//
// Takes one item per cycle while full is low: bank-status updates and scan requests.
// The front writes updates into the per-bank tables at the accepting edge and
// reads the tables for a request at that same edge; the next cycle it classifies
// the request (ready, priority, eligibility) and writes it into a four-entry queue.
// The back folds one request per cycle, except while a scan-ending request is held,
// against the running best and posts the winner into a one-entry result register,
// which clears empty, at scan end once its last request has passed the front's
// stage register and the queue. Sustained rate is one item per cycle while full is
// low, set by the single fold compare in the back. Only a scan-ending request waits
// for the result register; full rises when the queue holds four requests, or three
// with one more in the front's stage register, which happens only while a result
// sits unpopped. Banks at or above NUM_BANKS read as idle with no miss and no
// previous row and ignore updates. Write the threshold only while idle.
module frfcfs_request_selector #(
   parameter int NUM_BANKS = 64,
   parameter int MAX_SCAN  = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  frfcfs_pkg::req_type req_data,
   output logic                empty,
   input  logic                pop,
   output frfcfs_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_data
);
   logic [7:0] thr_ff;
   logic acc, cls_v, q_full, q_afull, q_empty, q_pop;
   frfcfs_pkg::cls_type cls_w, cls_q;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= frfcfs_pkg::FETCH_THRESHOLD_RESET;
      else if (csr_valid) thr_ff <= csr_data;
   end

   // Hold the input while the queue could not take the request in the stage register.
   assign full = q_full || (q_afull && cls_v);
   assign acc = push && !full;

   frfcfs_front #(.NUM_BANKS(NUM_BANKS)) u_front (
      .clock(clock), .reset(reset), .in_valid(acc), .in_req(req_data),
      .fetch_threshold(thr_ff), .cls_valid(cls_v), .cls(cls_w));

   frfcfs_fifo #(.DEPTH(4)) u_fifo (
      .clock(clock), .reset(reset), .wr_en(cls_v), .wr_data(cls_w), .full(q_full),
      .almost_full(q_afull), .rd_en(q_pop), .rd_data(cls_q), .empty(q_empty));

   frfcfs_back #(.MAX_SCAN(MAX_SCAN)) u_back (
      .clock(clock), .reset(reset), .cls_empty(q_empty), .cls(cls_q), .cls_pop(q_pop),
      .rsp_empty(empty), .rsp_pop(pop), .rsp_data(rsp_data));
endmodule

>>> tb/sv/tb.sv
// Self-checking bench for frfcfs_request_selector: directed table, then random scans.
// Depends on frfcfs_pkg and the selector RTL; the prediction is computed locally.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBANK = 64;
   localparam int SCAN_MAX = 64;
   localparam int WATCHDOG = 20000;

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic full;
   frfcfs_pkg::req_type req_data = '0;
   logic empty;
   logic pop = 0;
   frfcfs_pkg::rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [7:0] csr_data = '0;

   frfcfs_request_selector uut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Selector shadow state.
   logic [7:0]  thresh;
   logic [16:0] open_row [NBANK];
   logic        miss_flag [NBANK];
   logic        idle_flag [NBANK];
   int          scan_pos;
   logic [5:0]  win_pos;
   logic [31:0] win_arrival;
   logic        win_ready;
   logic [1:0]  win_prio;
   logic        win_elig;

   frfcfs_pkg::rsp_type winners_q[$];
   int errors = 0;
   int quiet = 0;
   bit no_idle = 0;

   function automatic logic [1:0] cmd_rank(logic [3:0] rule, logic [3:0] cmd);
      case (rule)
         frfcfs_pkg::RULE_TBL0: return cmd == frfcfs_pkg::CMD_RD ? 2'd1 : 2'd0;
         frfcfs_pkg::RULE_TBL1: return cmd == frfcfs_pkg::CMD_NDP_DB_RD ? 2'd1 : 2'd0;
         frfcfs_pkg::RULE_TBL2: return cmd == frfcfs_pkg::CMD_NDP_DB_WR ? 2'd1 : 2'd0;
         frfcfs_pkg::RULE_TBL3:
            return cmd == frfcfs_pkg::CMD_NDP_DRAM_RD ? 2'd2 :
                   (cmd == frfcfs_pkg::CMD_NDP_DRAM_RDA ? 2'd1 : 2'd0);
         frfcfs_pkg::RULE_TBL4:
            return cmd == frfcfs_pkg::CMD_NDP_DRAM_WR ? 2'd2 :
                   (cmd == frfcfs_pkg::CMD_NDP_DRAM_WRA ? 2'd1 : 2'd0);
         frfcfs_pkg::RULE_TBL5:
            return cmd == frfcfs_pkg::CMD_NDP_DB_RD ? 2'd3 :
                   (cmd == frfcfs_pkg::CMD_NDP_DRAM_RD ? 2'd2 :
                   (cmd == frfcfs_pkg::CMD_NDP_DRAM_RDA ? 2'd1 : 2'd0));
         frfcfs_pkg::RULE_TBL6: return cmd == frfcfs_pkg::CMD_WR ? 2'd1 : 2'd0;
         default: return 2'd0;
      endcase
   endfunction

   task automatic clear_shadow();
      thresh = frfcfs_pkg::FETCH_THRESHOLD_RESET;
      for (int i = 0; i < NBANK; i++) begin
         open_row[i] = '0;
         miss_flag[i] = 0;
         idle_flag[i] = 1;
      end
      scan_pos = 0;
      win_pos = '0;
      win_arrival = '0;
      win_ready = 0;
      win_prio = '0;
      win_elig = 0;
   endtask

   // Fold one accepted item into the shadow; queue the winner at scan end.
   task automatic fold_item(frfcfs_pkg::req_type r);
      logic low, rdy, elig, take, tbl;
      logic [1:0] pr;
      frfcfs_pkg::rsp_type w;
      tbl = r.select_rule >= frfcfs_pkg::RULE_TBL0 && r.select_rule <= frfcfs_pkg::RULE_TBL6;
      case (r.mode)
         frfcfs_pkg::MODE_SET_ROW:   open_row[r.bank_index] = {1'b1, r.row};
         frfcfs_pkg::MODE_MISS_SET:  miss_flag[r.bank_index] = 1;
         frfcfs_pkg::MODE_MISS_CLR:  miss_flag[r.bank_index] = 0;
         frfcfs_pkg::MODE_BANK_IDLE: idle_flag[r.bank_index] = 1;
         frfcfs_pkg::MODE_BANK_BUSY: idle_flag[r.bank_index] = 0;
         frfcfs_pkg::MODE_REQUEST: begin
            low = r.command == frfcfs_pkg::CMD_ACT && idle_flag[r.bank_index] &&
                  miss_flag[r.bank_index] && open_row[r.bank_index] == {1'b1, r.row};
            rdy = !low && r.timing_ready;
            elig = (r.is_read ? (r.end_command == frfcfs_pkg::CMD_RD
                                 || r.end_command == frfcfs_pkg::CMD_RDA)
                              : (r.end_command == frfcfs_pkg::CMD_WR
                                 || r.end_command == frfcfs_pkg::CMD_WRA))
                   && r.fetch_count < thresh;
            pr = tbl ? cmd_rank(r.select_rule, r.command) : 2'd0;
            if (r.select_rule == frfcfs_pkg::RULE_PRE) rdy = rdy && elig;
            if (tbl) rdy = rdy && pr != 2'd0;
            if (scan_pos == 0) take = 1;
            else if (rdy != win_ready) take = rdy;
            else if (tbl && rdy && pr != win_prio) take = pr > win_prio;
            else take = r.arrival < win_arrival;
            if (take) begin
               win_pos = scan_pos[5:0];
               win_arrival = r.arrival;
               win_ready = rdy;
               win_prio = pr;
               win_elig = elig;
            end
            if (r.last || scan_pos >= SCAN_MAX - 1) begin
               w.chosen_position = win_pos;
               w.found = r.select_rule == frfcfs_pkg::RULE_PRE ? win_elig : 1'b1;
               winners_q.push_back(w);
               scan_pos = 0;
            end else begin
               scan_pos++;
            end
         end
         default: ;
      endcase
   endtask

   // Check results and track stalls at the rising edge.
   always @(posedge clock) begin
      frfcfs_pkg::rsp_type e;
      if (!reset) begin
         if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready)) quiet <= 0;
         else quiet <= quiet + 1;
         if (pop && !empty) begin
            if (winners_q.size() == 0) begin
               $error("unexpected result pos=%0d found=%0d",
                      rsp_data.chosen_position, rsp_data.found);
               errors++;
            end else begin
               e = winners_q.pop_front();
               if (e.chosen_position !== rsp_data.chosen_position) begin
                  $error("chosen_position expected %0d actual %0d",
                         e.chosen_position, rsp_data.chosen_position);
                  errors++;
               end
               if (e.found !== rsp_data.found) begin
                  $error("found expected %0d actual %0d", e.found, rsp_data.found);
                  errors++;
               end
            end
         end
      end
   end

   // Randomly stall the result side at falling edges.
   always @(negedge clock)
      pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 11);

   always @(posedge clock)
      if (quiet >= WATCHDOG) begin
         $display("DONE: errors detected");
         $finish;
      end

   // Hold the item until accepted; idle between items at random.
   task automatic send_item(frfcfs_pkg::req_type r);
      while (!no_idle && $urandom_range(99) < 11) begin
         push <= 0;
         @(negedge clock);
      end
      req_data <= r;
      push <= 1;
      do @(posedge clock); while (full);
      fold_item(r);
      @(negedge clock);
   endtask

   task automatic write_threshold(logic [7:0] v);
      csr_data <= v;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      thresh = v;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain();
      push <= 0;
      while (winners_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic frfcfs_pkg::req_type make_req(logic [3:0] rule, logic [5:0] bank,
                                                    logic [15:0] row, logic [3:0] cmd,
                                                    logic [3:0] fin, logic rd, logic tr,
                                                    logic [7:0] fc, logic [31:0] arr,
                                                    logic lst);
      frfcfs_pkg::req_type r;
      r.mode = frfcfs_pkg::MODE_REQUEST;
      r.select_rule = rule;
      r.bank_index = bank;
      r.row = row;
      r.command = cmd;
      r.end_command = fin;
      r.is_read = rd;
      r.timing_ready = tr;
      r.fetch_count = fc;
      r.arrival = arr;
      r.last = lst;
      return r;
   endfunction

   function automatic frfcfs_pkg::req_type make_upd(logic [2:0] mode, logic [5:0] bank,
                                                    logic [15:0] row);
      frfcfs_pkg::req_type r;
      r = '0;
      r.mode = mode;
      r.bank_index = bank;
      r.row = row;
      return r;
   endfunction

   function automatic frfcfs_pkg::req_type rand_req(logic lst);
      frfcfs_pkg::req_type r;
      logic [3:0] rule;
      logic [5:0] bank;
      logic [15:0] row;
      logic [7:0] fc;
      logic [31:0] arr;
      rule = $urandom_range(99) < 90 ? 4'($urandom_range(8)) : 4'($urandom_range(15));
      bank = 6'($urandom_range(7) + 56 * $urandom_range(1));
      row = $urandom_range(99) < 60 ? 16'($urandom_range(3)) : 16'($urandom);
      fc = $urandom_range(99) < 70 ? 8'($urandom_range(15)) : 8'($urandom);
      arr = $urandom_range(99) < 70 ? 32'($urandom_range(12)) : 32'($urandom);
      r = make_req(rule, bank, row, 4'($urandom_range(15)), 4'($urandom_range(15)),
                   1'($urandom_range(1)), $urandom_range(99) < 75, fc, arr, lst);
      return r;
   endfunction

   initial begin
      frfcfs_pkg::req_type dir [$];
      int sent;
      int len;
      clear_shadow();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: demoted ACT, each rule, pre-request no-winner, extremes.
      dir.push_back(make_upd(frfcfs_pkg::MODE_SET_ROW, 6'd5, 16'hffff));
      dir.push_back(make_upd(frfcfs_pkg::MODE_MISS_SET, 6'd5, 16'd0));
      dir.push_back(make_req(frfcfs_pkg::RULE_FCFS, 6'd5, 16'hffff, frfcfs_pkg::CMD_ACT,
                             frfcfs_pkg::CMD_RD, 1'b1, 1'b1, 8'd0, 32'd0, 1'b0));
      dir.push_back(make_req(frfcfs_pkg::RULE_FCFS, 6'd63, 16'hffff, frfcfs_pkg::CMD_ACT,
                             frfcfs_pkg::CMD_RD, 1'b1, 1'b1, 8'd0, 32'hffffffff, 1'b1));
      dir.push_back(make_upd(frfcfs_pkg::MODE_BANK_BUSY, 6'd5, 16'd0));
      dir.push_back(make_req(frfcfs_pkg::RULE_FCFS, 6'd5, 16'hffff, frfcfs_pkg::CMD_ACT,
                             frfcfs_pkg::CMD_RD, 1'b1, 1'b1, 8'd0, 32'd9, 1'b0));
      dir.push_back(make_req(frfcfs_pkg::RULE_FCFS, 6'd5, 16'hffff, frfcfs_pkg::CMD_ACT,
                             frfcfs_pkg::CMD_RD, 1'b1, 1'b1, 8'd0, 32'd9, 1'b1));
      dir.push_back(make_upd(frfcfs_pkg::MODE_BANK_IDLE, 6'd5, 16'd0));
      dir.push_back(make_upd(frfcfs_pkg::MODE_MISS_CLR, 6'd5, 16'd0));
      dir.push_back(make_upd(3'd6, 6'd0, 16'd0));
      dir.push_back(make_upd(3'd7, 6'd0, 16'd0));
      dir.push_back(make_req(frfcfs_pkg::RULE_PRE, 6'd0, 16'd0, frfcfs_pkg::CMD_RD,
                             frfcfs_pkg::CMD_WR, 1'b1, 1'b1, 8'd255, 32'd3, 1'b0));
      dir.push_back(make_req(frfcfs_pkg::RULE_PRE, 6'd0, 16'd0, frfcfs_pkg::CMD_RD,
                             frfcfs_pkg::CMD_OTHER, 1'b0, 1'b1, 8'd0, 32'd1, 1'b1));
      dir.push_back(make_req(frfcfs_pkg::RULE_PRE, 6'd1, 16'd0, frfcfs_pkg::CMD_RD,
                             frfcfs_pkg::CMD_RDA, 1'b1, 1'b1, 8'd7, 32'd4, 1'b0));
      dir.push_back(make_req(frfcfs_pkg::RULE_PRE, 6'd1, 16'd0, frfcfs_pkg::CMD_WR,
                             frfcfs_pkg::CMD_WRA, 1'b0, 1'b1, 8'd8, 32'd2, 1'b1));
      for (int rl = frfcfs_pkg::RULE_TBL0; rl <= frfcfs_pkg::RULE_TBL6; rl++) begin
         dir.push_back(make_req(4'(rl), 6'd2, 16'd0, frfcfs_pkg::CMD_NDP_DB_RD,
                                frfcfs_pkg::CMD_OTHER, 1'b0, 1'b1, 8'd0, 32'd5, 1'b0));
         dir.push_back(make_req(4'(rl), 6'd2, 16'd0, 4'(rl * 3), frfcfs_pkg::CMD_OTHER,
                                1'b0, 1'b1, 8'd0, 32'd5, rl[0]));
      end
      dir.push_back(make_req(4'd15, 6'd3, 16'd0, 4'd15, 4'd15, 1'b1, 1'b0, 8'd0, 32'd5,
                             1'b1));
      foreach (dir[i]) send_item(dir[i]);
      drain();

      // Random scans across several thresholds, extremes included.
      sent = 0;
      for (int ph = 0; ph < 5; ph++) begin
         write_threshold(ph == 0 ? 8'd0 : ph == 1 ? 8'd255 : ph == 2 ? 8'd8 : 8'($urandom));
         no_idle = ph == 3;
         for (int k = 0; k < 360; k++) begin
            if ($urandom_range(99) < 25) begin
               send_item(make_upd(3'($urandom_range(4)),
                                  6'($urandom_range(7) + 56 * $urandom_range(1)),
                                  16'($urandom_range(3))));
            end else begin
               len = $urandom_range(99) < 3 ? SCAN_MAX + 2 : $urandom_range(1, 10);
               for (int j = 0; j < len; j++) send_item(rand_req(j == len - 1));
               k += len - 1;
            end
         end
         // Close any open scan before the threshold moves.
         send_item(rand_req(1'b1));
         drain();
      end
      no_idle = 0;
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
